// ===== rtl/kwm_pkg.sv =====
// Shared constants and controller/datapath interface types for the k-way merge block.
package kwm_pkg;

  // Sizing
  localparam int LISTS       = 8;
  localparam int LIST_DEPTH  = 8;
  localparam int VALUE_WIDTH = 32;

  // Fixed port field widths
  localparam int ID_W    = 3;
  localparam int FIELD_W = 32;

  // Derived widths
  localparam int LID_W   = $clog2(LISTS);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int ENTRIES = LISTS * LIST_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int TOT_W   = $clog2(ENTRIES + 1);
  localparam int TREE_N  = 1 << LID_W;

  // Command codes carried on the cmd port
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_MERGE  = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic             append;       // store the beat's value into its list
    logic             merge_empty;  // load the all-empty result
    logic             load_rd;      // prefetch the first entry of list load_idx
    logic [LID_W-1:0] load_idx;
    logic             pick;         // register the smallest head as a result
    logic             refill_rd;    // fetch the next entry of the picked list
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic none_left;  // no stored values at all
    logic one_left;   // exactly one stored value not yet emitted
  } dp_stat_t;

endpackage

// ===== rtl/kwm_ctrl.sv =====
// Sequencer for appends, head prefetch and the pick/refill loop of a merge.
module kwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  output logic               busy,
  output kwm_pkg::dp_cmd_t   dcmd,
  input  kwm_pkg::dp_stat_t  dstat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [kwm_pkg::LID_W-1:0] load_cnt;
  logic [kwm_pkg::LID_W-1:0] load_cnt_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next    = state;
    load_cnt_next = load_cnt;
    dcmd          = '0;
    dcmd.load_idx = load_cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == kwm_pkg::CMD_APPEND) begin
            dcmd.append = 1'b1;
          end else if (dstat.none_left) begin
            dcmd.merge_empty = 1'b1;
          end else begin
            state_next    = S_LOAD;
            load_cnt_next = '0;
          end
        end
      end
      S_LOAD: begin
        dcmd.load_rd  = 1'b1;
        load_cnt_next = load_cnt + 1'b1;
        if (load_cnt == kwm_pkg::LID_W'(kwm_pkg::LISTS - 1)) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        // last fetched head lands in its register this cycle
        state_next = S_PICK;
      end
      S_PICK: begin
        dcmd.pick = 1'b1;
        if (dstat.one_left) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        dcmd.refill_rd = 1'b1;
        state_next     = S_FILL;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      load_cnt <= '0;
    end else begin
      state    <= state_next;
      load_cnt <= load_cnt_next;
    end
  end

`ifndef ASSERT_OFF
  // a merge pass only starts from an accepted merge beat
  a_busy_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && ($past(cmd) == kwm_pkg::CMD_MERGE))
    else $error("merge pass started without a merge beat");

  // never pick when nothing is left to emit
  a_pick_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> !dstat.none_left)
    else $error("pick with no stored values");
`endif

endmodule

// ===== rtl/kwm_dp.sv =====
// Datapath: element memory, per-list counters, head registers, min tree and result registers.
module kwm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kwm_pkg::dp_cmd_t              dcmd,
  output kwm_pkg::dp_stat_t             dstat,
  input  logic [kwm_pkg::ID_W-1:0]      list_id,
  input  logic signed [kwm_pkg::FIELD_W-1:0] value,
  output logic                          result_valid,
  output logic signed [kwm_pkg::FIELD_W-1:0] merged_value,
  output logic                          is_last,
  output logic                          all_empty,
  output logic                          overflowed
);

  // Entry address of position pos in list lid; positions past the end fold to 0
  function automatic logic [kwm_pkg::ADDR_W-1:0] entry_addr(
    input logic [kwm_pkg::LID_W-1:0] lid,
    input logic [kwm_pkg::CNT_W-1:0] pos
  );
    logic [kwm_pkg::ADDR_W-1:0] p;
    p = (pos < kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH)) ? kwm_pkg::ADDR_W'(pos) : '0;
    return kwm_pkg::ADDR_W'(lid) * kwm_pkg::ADDR_W'(kwm_pkg::LIST_DEPTH) + p;
  endfunction

  // Input value sign-extended or truncated to the stored width
  function automatic kwm_pkg::elem_t to_elem(input logic signed [kwm_pkg::FIELD_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[kwm_pkg::VALUE_WIDTH-1:0];
  endfunction

  // Stored value sign-extended, low field bits kept
  function automatic logic signed [kwm_pkg::FIELD_W-1:0] from_elem(input kwm_pkg::elem_t e);
    logic signed [63:0] w;
    w = 64'(e);
    return w[kwm_pkg::FIELD_W-1:0];
  endfunction

  kwm_pkg::elem_t              mem [kwm_pkg::ENTRIES];
  kwm_pkg::elem_t              head [kwm_pkg::LISTS];
  logic [kwm_pkg::CNT_W-1:0]   fill [kwm_pkg::LISTS];
  logic [kwm_pkg::CNT_W-1:0]   rpos [kwm_pkg::LISTS];
  logic [kwm_pkg::TOT_W-1:0]   total;
  logic                        overflow_seen;

  logic                        lid_ok;
  logic [kwm_pkg::LID_W-1:0]   lid;
  logic                        full;
  logic                        wr_en;
  logic [kwm_pkg::ADDR_W-1:0]  wr_addr;

  logic                        rd_en;
  logic [kwm_pkg::LID_W-1:0]   rd_lid;
  logic [kwm_pkg::ADDR_W-1:0]  rd_addr;
  kwm_pkg::elem_t              rd_data;
  logic                        rd_pend;
  logic [kwm_pkg::LID_W-1:0]   rd_idx;
  logic [kwm_pkg::LID_W-1:0]   best_idx;

  logic                        clear;

  kwm_pkg::elem_t              node_v  [kwm_pkg::TREE_N];
  logic                        node_ok [kwm_pkg::TREE_N];
  logic [kwm_pkg::LID_W-1:0]   node_i  [kwm_pkg::TREE_N];

  // Status
  assign dstat.none_left = (total == '0);
  assign dstat.one_left  = (total == kwm_pkg::TOT_W'(1));
  assign clear = dcmd.merge_empty || (dcmd.pick && dstat.one_left);

  // Append decode
  assign lid_ok  = (32'(list_id) < kwm_pkg::LISTS);
  assign lid     = kwm_pkg::LID_W'(list_id);
  assign full    = (fill[lid] >= kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH));
  assign wr_en   = dcmd.append && lid_ok && !full;
  assign wr_addr = entry_addr(lid, fill[lid]);

  // Read port: prefetch of position 0, or refill of the picked list
  assign rd_en   = dcmd.load_rd || dcmd.refill_rd;
  assign rd_lid  = dcmd.load_rd ? dcmd.load_idx : best_idx;
  assign rd_addr = entry_addr(rd_lid, dcmd.load_rd ? '0 : rpos[best_idx]);

  // Element memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= to_elem(value);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    rd_idx <= rd_lid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  // Head registers take the fetched entry from the registered read data while a read is pending
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      head[rd_idx] <= rd_data;
    end
  end

  // Per-list fill and read positions, element total, sticky overflow
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int l = 0; l < kwm_pkg::LISTS; l++) begin
        fill[l] <= '0;
        rpos[l] <= '0;
      end
      total         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (dcmd.append && lid_ok) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          fill[lid] <= fill[lid] + 1'b1;
          total     <= total + 1'b1;
        end
      end
      if (dcmd.pick) begin
        rpos[node_i[0]] <= rpos[node_i[0]] + 1'b1;
        total           <= total - 1'b1;
      end
    end
  end

  // Tournament tree over the heads; on a tie the lower list wins
  always_comb begin
    logic take_r;
    for (int i = 0; i < kwm_pkg::TREE_N; i++) begin
      node_i[i] = kwm_pkg::LID_W'(i);
      if (i < kwm_pkg::LISTS) begin
        node_v[i]  = head[i];
        node_ok[i] = (rpos[i] < fill[i]);
      end else begin
        node_v[i]  = '0;
        node_ok[i] = 1'b0;
      end
    end
    for (int s = 1; s < kwm_pkg::TREE_N; s = s * 2) begin
      for (int i = 0; i < kwm_pkg::TREE_N; i = i + 2 * s) begin
        take_r = node_ok[i+s] && (!node_ok[i] || (node_v[i+s] < node_v[i]));
        if (take_r) begin
          node_v[i]  = node_v[i+s];
          node_ok[i] = 1'b1;
          node_i[i]  = node_i[i+s];
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dcmd.pick || dcmd.merge_empty;
    end
  end

  // Result payload and picked list
  always_ff @(posedge clk) begin
    if (dcmd.pick) begin
      merged_value <= from_elem(node_v[0]);
      is_last      <= dstat.one_left;
      all_empty    <= 1'b0;
      overflowed   <= overflow_seen;
      best_idx     <= node_i[0];
    end else if (dcmd.merge_empty) begin
      merged_value <= '0;
      is_last      <= 1'b1;
      all_empty    <= 1'b1;
      overflowed   <= overflow_seen;
    end
  end

`ifndef ASSERT_OFF
  // an all-empty beat is the only beat of its merge and carries zero
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && all_empty |-> is_last && (merged_value == '0))
    else $error("malformed all-empty beat");

  // after the final beat every list has been drained and cleared
  a_last_drained: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_last |-> (total == '0) && !overflow_seen)
    else $error("final beat with values still stored");

  // every beat comes from a pick or an empty merge in the cycle before
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(dcmd.pick || dcmd.merge_empty))
    else $error("result beat without a source");
`endif

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// Top level of the k-way sorted merge: controller plus datapath.
// Append or empty merge: busy stays low; an empty merge's result comes next cycle.
// Merge of N > 0 values: busy while the head of each list is prefetched, then for each
// value a pick, then (but for the last) a refill read and a head load.
// Results are strobed on result_valid for one cycle and cannot be stalled.
// Synchronous reset clears lists, counters and overflow; memory contents are kept.
module k_way_sorted_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd,
  input  logic [kwm_pkg::ID_W-1:0]           list_id,
  input  logic signed [kwm_pkg::FIELD_W-1:0] value,
  output logic                               result_valid,
  output logic signed [kwm_pkg::FIELD_W-1:0] merged_value,
  output logic                               is_last,
  output logic                               all_empty,
  output logic                               overflowed
);

  kwm_pkg::dp_cmd_t  dcmd;
  kwm_pkg::dp_stat_t dstat;

  kwm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .dcmd  (dcmd),
    .dstat (dstat)
  );

  kwm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dcmd         (dcmd),
    .dstat        (dstat),
    .list_id      (list_id),
    .value        (value),
    .result_valid (result_valid),
    .merged_value (merged_value),
    .is_last      (is_last),
    .all_empty    (all_empty),
    .overflowed   (overflowed)
  );

endmodule
